### src/rrt_pkg.sv
// shared types, constants and opcodes for the tree extension block
package rrt_pkg;

	localparam int MAX_NODES_DEF  = 1024;
	localparam int COORD_BITS_DEF = 24;
	localparam int CW             = COORD_BITS_DEF;
	localparam int STEP_W         = 23;
	localparam int LIM_W          = 10;
	localparam int IDX_W          = 10;
	localparam int LVL_W          = 11;
	localparam int CFG_IDX_W      = 3;
	localparam logic [LVL_W-1:0] LEVEL_MAX = 11'd2047;

	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GXLO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GXHI   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GYLO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GYHI   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXTLIM = 3'd5;

	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_EXTEND  = 1'b1;

	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_GOAL     = 3'd1;
	localparam logic [2:0] ST_LIMIT    = 3'd2;
	localparam logic [2:0] ST_FINISHED = 3'd3;
	localparam logic [2:0] ST_RESTART  = 3'd4;

	typedef struct packed {
		logic                  op;
		logic signed [CW-1:0]  point_x;
		logic signed [CW-1:0]  point_y;
		logic signed [CW-1:0]  point_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [CW-1:0]  new_x;
		logic signed [CW-1:0]  new_y;
		logic signed [CW-1:0]  new_z;
		logic [IDX_W-1:0]      node_index;
		logic [IDX_W-1:0]      parent_index;
		logic [LVL_W-1:0]      node_level;
		logic [2:0]            status;
	} out_beat_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;      // capture input beat
		logic restart;      // write start node
		logic scan_start;   // begin nearest search
		logic steer_start;  // begin sqrt/divide
		logic commit;       // write new node, build result
		logic short_res;    // build result with given status, nothing stored
		logic [2:0] short_status;
	} rrt_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_done;
		logic steer_done;
		logic op;
		logic limit_hit;
	} rrt_sts_t;

endpackage

### src/rrt_ram.sv
// generic single port ram with registered read
module rrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### src/rrt_ctrl.sv
// controller state machine for the tree extension block
module rrt_ctrl import rrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  logic     finished,
	input  rrt_sts_t sts,
	output rrt_cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_SCAN   = 6'b000100,
		S_STEER  = 6'b001000,
		S_COMMIT = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.op == OP_RESTART) begin
					cmd.restart = 1'b1;
					state_d = S_OUT;
				end else if (finished) begin
					cmd.short_res = 1'b1;
					cmd.short_status = ST_FINISHED;
					state_d = S_OUT;
				end else if (sts.limit_hit) begin
					cmd.short_res = 1'b1;
					cmd.short_status = ST_LIMIT;
					state_d = S_OUT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					cmd.steer_start = 1'b1;
					state_d = S_STEER;
				end
			end
			S_STEER: begin
				if (sts.steer_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### src/rrt_dp.sv
// datapath: node tables, nearest scan, sqrt and divide steering, goal test
module rrt_dp import rrt_pkg::*; #(
	parameter int MAX_NODES  = MAX_NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  in_beat_t            in_beat,
	input  rrt_cmd_t            cmd,
	output rrt_sts_t            sts,
	input  logic [STEP_W-1:0]   step_length,
	input  logic signed [CW-1:0] goal_x_low,
	input  logic signed [CW-1:0] goal_x_high,
	input  logic signed [CW-1:0] goal_y_low,
	input  logic signed [CW-1:0] goal_y_high,
	input  logic [LIM_W-1:0]    extension_limit,
	output logic                finished,
	output out_beat_t           out_beat
);
	localparam int AW  = $clog2(MAX_NODES);
	localparam int CNW = AW + 1;
	localparam int C   = CW;
	localparam int DW  = C + 1;          // difference width
	localparam int SQW = 2 * DW + 2;     // sum of three squares
	localparam int RW  = DW + 2;         // sqrt result width
	localparam int PW  = DW + STEP_W;    // product width for steering

	// captured input point
	logic              op_q;
	logic signed [C-1:0] px_q, py_q, pz_q;
	logic [CNW-1:0]    count_q;
	logic              fin_q;

	// ram ports
	logic              we;
	logic [AW-1:0]     addr;
	logic [C-1:0]      wx, wy, wz, rx, ry, rz;
	logic [LVL_W-1:0]  wl, rl;

	rrt_ram #(.WIDTH(C), .DEPTH(MAX_NODES)) u_ram_x (
		.clk(clk), .we(we), .addr(addr), .wdata(wx), .rdata(rx));
	rrt_ram #(.WIDTH(C), .DEPTH(MAX_NODES)) u_ram_y (
		.clk(clk), .we(we), .addr(addr), .wdata(wy), .rdata(ry));
	rrt_ram #(.WIDTH(C), .DEPTH(MAX_NODES)) u_ram_z (
		.clk(clk), .we(we), .addr(addr), .wdata(wz), .rdata(rz));
	rrt_ram #(.WIDTH(LVL_W), .DEPTH(MAX_NODES)) u_ram_l (
		.clk(clk), .we(we), .addr(addr), .wdata(wl), .rdata(rl));

	// scan pipeline: address issue, read (s1), squares (s2), sum (s3), compare
	logic              scan_q;
	logic [CNW-1:0]    rd_ptr_q;
	logic              v_s1, v_s2, v_s3;
	logic [AW-1:0]     idx_s1, idx_s2, idx_s3;
	logic [C-1:0]      nx_s2, ny_s2, nz_s2, nx_s3, ny_s3, nz_s3;
	logic [LVL_W-1:0]  lv_s2, lv_s3;
	logic [2*DW-1:0]   sx_s3, sy_s3, sz_s3;
	logic [SQW-1:0]    d_s3;
	logic              best_v_q;
	logic [SQW-1:0]    best_d_q;
	logic [AW-1:0]     best_i_q;
	logic signed [C-1:0] best_x_q, best_y_q, best_z_q;
	logic [LVL_W-1:0]  best_l_q;

	// steering unit
	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_SQRT = 5'b00010,
		T_MUL  = 5'b00100,
		T_DIV  = 5'b01000,
		T_DONE = 5'b10000
	} tstate_t;
	tstate_t           t_q;
	logic              far_q;
	logic [RW-1:0]     root_q;
	logic [$clog2(RW+1)-1:0] bit_q;
	logic [1:0]        comp_q;
	logic              neg_q;
	logic [PW-1:0]     num_q, quo_q;
	logic [PW+RW-1:0]  div_rem_q;
	logic [$clog2(PW+1)-1:0] dcnt_q;
	logic signed [C-1:0] sx_q, sy_q, sz_q;

	// ceiling fixup happens on entry to multiply: root is floor, add one if inexact
	logic fix_q;
	logic out_goal;

	logic signed [DW-1:0] dxs, dys, dzs;
	logic [2*STEP_W-1:0]  lim2;
	logic [CNW-1:0]       ext_lim;

	assign ext_lim = CNW'(extension_limit);

	assign sts.op = op_q;
	assign sts.limit_hit = ((count_q - CNW'(1)) >= ext_lim) ||
		(count_q >= CNW'(MAX_NODES));
	assign sts.scan_done = scan_q && !v_s1 && !v_s2 && !v_s3 && (rd_ptr_q >= count_q);
	assign sts.steer_done = (t_q == T_DONE);
	assign finished = fin_q;

	assign we = cmd.restart || cmd.commit;
	always_comb begin
		if (cmd.restart) begin
			addr = '0;
			wx = px_q; wy = py_q; wz = pz_q;
			wl = LVL_W'(1);
		end else if (cmd.commit) begin
			addr = count_q[AW-1:0];
			wx = sx_q; wy = sy_q; wz = sz_q;
			wl = (best_l_q == LEVEL_MAX) ? LEVEL_MAX : best_l_q + LVL_W'(1);
		end else begin
			addr = rd_ptr_q[AW-1:0];
			wx = '0; wy = '0; wz = '0; wl = '0;
		end
	end

	function automatic logic [DW-1:0] absd(input logic signed [DW-1:0] v);
		absd = v[DW-1] ? DW'(-v) : v;
	endfunction

	assign dxs = DW'(signed'(nx_s2)) - DW'(px_q);
	assign dys = DW'(signed'(ny_s2)) - DW'(py_q);
	assign dzs = DW'(signed'(nz_s2)) - DW'(pz_q);
	assign lim2 = step_length * step_length;

	assign out_goal = sx_q >= C'(goal_x_low) && sx_q <= C'(goal_x_high) &&
		sy_q >= C'(goal_y_low) && sy_q <= C'(goal_y_high);

	// steering component selection
	logic signed [DW-1:0] comp_d;
	always_comb begin
		case (comp_q)
			2'd0: comp_d = DW'(px_q) - DW'(best_x_q);
			2'd1: comp_d = DW'(py_q) - DW'(best_y_q);
			default: comp_d = DW'(pz_q) - DW'(best_z_q);
		endcase
	end

	logic [SQW-1:0]  trial;
	logic [PW+RW-1:0] dtrial;
	logic signed [C-1:0] base_c, sum_c;
	assign trial = SQW'(root_q | (RW'(1) << bit_q)) * SQW'(root_q | (RW'(1) << bit_q));
	assign dtrial = {div_rem_q[PW+RW-2:0], num_q[PW-1]};
	always_comb begin
		case (comp_q)
			2'd0: base_c = best_x_q;
			2'd1: base_c = best_y_q;
			default: base_c = best_z_q;
		endcase
		sum_c = base_c + (neg_q ? -C'(quo_q) : C'(quo_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= in_beat.op;
			px_q <= in_beat.point_x[C-1:0];
			py_q <= in_beat.point_y[C-1:0];
			pz_q <= in_beat.point_z[C-1:0];
		end
		// scan datapath registers
		idx_s1 <= rd_ptr_q[AW-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		nx_s2 <= rx; ny_s2 <= ry; nz_s2 <= rz; lv_s2 <= rl;
		nx_s3 <= nx_s2; ny_s3 <= ny_s2; nz_s3 <= nz_s2; lv_s3 <= lv_s2;
		sx_s3 <= (2*DW)'(absd(dxs)) * (2*DW)'(absd(dxs));
		sy_s3 <= (2*DW)'(absd(dys)) * (2*DW)'(absd(dys));
		sz_s3 <= (2*DW)'(absd(dzs)) * (2*DW)'(absd(dzs));
		if (v_s3 && (!best_v_q || d_s3 < best_d_q)) begin
			best_d_q <= d_s3;
			best_i_q <= idx_s3;
			best_x_q <= nx_s3; best_y_q <= ny_s3; best_z_q <= nz_s3;
			best_l_q <= lv_s3;
		end
		// steering unit payload
		case (t_q)
			T_IDLE: begin
				if (cmd.steer_start) begin
					far_q <= (SQW'(lim2) < best_d_q);
					root_q <= '0;
					// squared distance is below 2^(2*C+2), so the floor root fits DW bits
					bit_q <= ($bits(bit_q))'(DW - 1);
					comp_q <= 2'd0;
				end
			end
			T_SQRT: begin
				if (trial <= best_d_q) begin
					root_q <= root_q | (RW'(1) << bit_q);
				end
				if (bit_q != '0) begin
					bit_q <= bit_q - ($bits(bit_q))'(1);
				end else begin
					comp_q <= 2'd0;
				end
			end
			T_MUL: begin
				if (fix_q && (SQW'(root_q) * SQW'(root_q) != best_d_q)) begin
					root_q <= root_q + RW'(1);
				end
				if (far_q) begin
					neg_q <= comp_d[DW-1];
					num_q <= PW'(absd(comp_d)) * PW'(step_length);
				end
				div_rem_q <= '0;
				quo_q <= '0;
				dcnt_q <= ($bits(dcnt_q))'(PW);
			end
			T_DIV: begin
				if (dcnt_q != '0) begin
					num_q <= num_q << 1;
					if (dtrial >= (PW+RW)'(root_q)) begin
						div_rem_q <= dtrial - (PW+RW)'(root_q);
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						div_rem_q <= dtrial;
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - ($bits(dcnt_q))'(1);
				end else begin
					case (comp_q)
						2'd0: sx_q <= sum_c;
						2'd1: sy_q <= sum_c;
						default: sz_q <= sum_c;
					endcase
					comp_q <= comp_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (t_q == T_MUL && !far_q) begin
			sx_q <= px_q; sy_q <= py_q; sz_q <= pz_q;
		end
		// result beat
		if (cmd.restart) begin
			out_beat.new_x <= CW'(px_q);
			out_beat.new_y <= CW'(py_q);
			out_beat.new_z <= CW'(pz_q);
			out_beat.node_index <= '0;
			out_beat.parent_index <= '0;
			out_beat.node_level <= LVL_W'(1);
			out_beat.status <= ST_RESTART;
		end else if (cmd.short_res) begin
			out_beat <= '{status: cmd.short_status, default: '0};
		end else if (cmd.commit) begin
			out_beat.new_x <= CW'(sx_q);
			out_beat.new_y <= CW'(sy_q);
			out_beat.new_z <= CW'(sz_q);
			out_beat.node_index <= IDX_W'(count_q);
			out_beat.parent_index <= IDX_W'(best_i_q);
			out_beat.node_level <= wl;
			out_beat.status <= out_goal ? ST_GOAL : ST_STORED;
		end
	end

	assign d_s3 = SQW'(sx_s3) + SQW'(sy_s3) + SQW'(sz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fin_q <= 1'b1;
			scan_q <= 1'b0;
			rd_ptr_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			best_v_q <= 1'b0;
			t_q <= T_IDLE;
			fix_q <= 1'b0;
		end else begin
			v_s1 <= scan_q && (rd_ptr_q < count_q);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.scan_start) begin
				scan_q <= 1'b1;
				rd_ptr_q <= '0;
				best_v_q <= 1'b0;
			end else if (scan_q) begin
				if (rd_ptr_q < count_q) begin
					rd_ptr_q <= rd_ptr_q + CNW'(1);
				end
				if (v_s3) begin
					best_v_q <= 1'b1;
				end
				if (sts.scan_done) begin
					scan_q <= 1'b0;
				end
			end
			if (cmd.restart) begin
				count_q <= CNW'(1);
				fin_q <= 1'b0;
			end else if (cmd.short_res && cmd.short_status == ST_LIMIT) begin
				fin_q <= 1'b1;
			end else if (cmd.commit) begin
				count_q <= count_q + CNW'(1);
				if (out_goal) begin
					fin_q <= 1'b1;
				end
			end
			fix_q <= 1'b0;
			case (t_q)
				T_IDLE: if (cmd.steer_start) t_q <= T_SQRT;
				T_SQRT: if (bit_q == '0) begin
					t_q <= T_MUL;
					fix_q <= 1'b1;
				end
				T_MUL: t_q <= far_q ? T_DIV : T_DONE;
				T_DIV: if (dcnt_q == '0) t_q <= (comp_q == 2'd2) ? T_DONE : T_MUL;
				T_DONE: t_q <= T_IDLE;
				default: t_q <= T_IDLE;
			endcase
		end
	end
endmodule

### src/rrt_tree_extend_step.sv
// top level of the rapidly-exploring random tree extension block
// restart and rejected beats go from capture through the decide state to the result;
// an extend beat scans the n stored nodes (one ram read a cycle), then runs a
// bit-serial square root and, if the point lies beyond one step, a multiply and a
// serial divide per axis; one beat in flight at a time
// reset clears the controller, node count and sets the finished flag (no tree)
module rrt_tree_extend_step import rrt_pkg::*; #(
	parameter int MAX_NODES  = MAX_NODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CW-1:0]        cfg_data
);
	// configuration registers
	logic [STEP_W-1:0]    step_q;
	logic signed [CW-1:0] gxlo_q, gxhi_q, gylo_q, gyhi_q;
	logic [LIM_W-1:0]     extlim_q;

	rrt_cmd_t cmd;
	rrt_sts_t sts;
	logic     finished;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_W'(256);
			gxlo_q   <= '0;
			gxhi_q   <= '0;
			gylo_q   <= '0;
			gyhi_q   <= '0;
			extlim_q <= LIM_W'(1000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				REG_GXLO:   gxlo_q   <= cfg_data;
				REG_GXHI:   gxhi_q   <= cfg_data;
				REG_GYLO:   gylo_q   <= cfg_data;
				REG_GYHI:   gyhi_q   <= cfg_data;
				REG_EXTLIM: extlim_q <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// controller sequences decide, scan, steer and commit
	rrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.finished(finished), .sts(sts), .cmd(cmd)
	);

	// datapath holds the node tables and the arithmetic units
	rrt_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_beat(in_data), .cmd(cmd), .sts(sts),
		.step_length(step_q),
		.goal_x_low(gxlo_q), .goal_x_high(gxhi_q),
		.goal_y_low(gylo_q), .goal_y_high(gyhi_q),
		.extension_limit(extlim_q),
		.finished(finished), .out_beat(out_data)
	);

	// result must hold while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed under stall");

	// no input taken while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted with result pending");

	// a restart result always reports level one
	a_restart_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_RESTART |-> out_data.node_level == LVL_W'(1))
		else $error("restart level wrong");
endmodule

### verif/rrt_checker.sv
// beat monitor, tree extension predictor and result scoreboard
module rrt_checker import rrt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_beat_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_beat_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CW-1:0]        cfg_data,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = MAX_NODES_DEF;

	longint signed   tree_x [NODES];
	longint signed   tree_y [NODES];
	longint signed   tree_z [NODES];
	int unsigned     tree_lvl [NODES];
	int unsigned     tree_size;
	bit              tree_done;

	longint unsigned step_len;
	longint signed   box_xlo, box_xhi, box_ylo, box_yhi;
	int unsigned     ext_limit;

	out_beat_t       expected_beats [$];
	int              mismatch_cnt;

	function automatic longint unsigned mag(longint signed v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// ceil of square root, squared distances stay below 2^50
	function automatic longint unsigned root_up(longint unsigned d);
		longint unsigned r, c;
		r = 0;
		for (int b = 26; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= d)
				r = c;
		end
		if (r * r != d)
			r++;
		return r;
	endfunction

	function automatic longint signed steer_part(longint signed d, longint unsigned m);
		longint unsigned q;
		q = (mag(d) * step_len) / m;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic out_beat_t extend_tree(in_beat_t b);
		out_beat_t r;
		longint signed px, py, pz, dx, dy, dz, nx, ny, nz;
		longint unsigned bd, dd, m;
		int unsigned best, lv, idx;
		r = '0;
		px = b.point_x;
		py = b.point_y;
		pz = b.point_z;
		if (b.op == OP_RESTART) begin
			tree_x[0] = px;
			tree_y[0] = py;
			tree_z[0] = pz;
			tree_lvl[0] = 1;
			tree_size = 1;
			tree_done = 0;
			r.new_x = b.point_x;
			r.new_y = b.point_y;
			r.new_z = b.point_z;
			r.node_level = 1;
			r.status = ST_RESTART;
			return r;
		end
		if (tree_done || tree_size == 0) begin
			r.status = ST_FINISHED;
			return r;
		end
		if (tree_size - 1 >= ext_limit || tree_size >= NODES) begin
			tree_done = 1;
			r.status = ST_LIMIT;
			return r;
		end
		best = 0;
		bd = 64'hFFFF_FFFF_FFFF_FFFF;
		for (int unsigned i = 0; i < tree_size; i++) begin
			dx = tree_x[i] - px;
			dy = tree_y[i] - py;
			dz = tree_z[i] - pz;
			dd = dx * dx + dy * dy + dz * dz;
			if (dd < bd) begin
				bd = dd;
				best = i;
			end
		end
		if (step_len * step_len < bd) begin
			m = root_up(bd);
			nx = tree_x[best] + steer_part(px - tree_x[best], m);
			ny = tree_y[best] + steer_part(py - tree_y[best], m);
			nz = tree_z[best] + steer_part(pz - tree_z[best], m);
		end else begin
			nx = px;
			ny = py;
			nz = pz;
		end
		lv = tree_lvl[best] + 1;
		if (lv > LEVEL_MAX)
			lv = LEVEL_MAX;
		idx = tree_size;
		tree_x[idx] = nx;
		tree_y[idx] = ny;
		tree_z[idx] = nz;
		tree_lvl[idx] = lv;
		tree_size++;
		r.status = ST_STORED;
		if (nx >= box_xlo && nx <= box_xhi && ny >= box_ylo && ny <= box_yhi) begin
			r.status = ST_GOAL;
			tree_done = 1;
		end
		r.new_x = nx[CW-1:0];
		r.new_y = ny[CW-1:0];
		r.new_z = nz[CW-1:0];
		r.node_index = idx[IDX_W-1:0];
		r.parent_index = best[IDX_W-1:0];
		r.node_level = lv[LVL_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("mismatch %s: expected %0h actual %0h", name, exp_v, act_v);
		end
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		if (!arst_n) begin
			tree_size = 0;
			tree_done = 1;
			step_len = 256;
			box_xlo = 0;
			box_xhi = 0;
			box_ylo = 0;
			box_yhi = 0;
			ext_limit = 1000;
			mismatch_cnt = 0;
			expected_beats.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEP:   step_len = cfg_data[STEP_W-1:0];
					REG_GXLO:   box_xlo = signed'(cfg_data);
					REG_GXHI:   box_xhi = signed'(cfg_data);
					REG_GYLO:   box_ylo = signed'(cfg_data);
					REG_GYHI:   box_yhi = signed'(cfg_data);
					REG_EXTLIM: ext_limit = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result beat %h", out_data);
				end else begin
					e = expected_beats.pop_front();
					check_field("new_x", e.new_x, out_data.new_x);
					check_field("new_y", e.new_y, out_data.new_y);
					check_field("new_z", e.new_z, out_data.new_z);
					check_field("node_index", e.node_index, out_data.node_index);
					check_field("parent_index", e.parent_index, out_data.parent_index);
					check_field("node_level", e.node_level, out_data.node_level);
					check_field("status", e.status, out_data.status);
				end
			end
			if (in_valid && !in_stall)
				expected_beats = {expected_beats, extend_tree(in_data)};
			errors <= mismatch_cnt;
			pending <= expected_beats.size();
		end
	end
endmodule

### verif/tb.sv
// stimulus, watchdog and verdict for the tree extension block
module tb;
	import rrt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_beat_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_beat_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CW-1:0]        cfg_data;
	int                   errors;
	int                   pending;
	int                   idle_cycles;
	int                   results_seen;

	rrt_tree_extend_step uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rrt_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// gap per beat, with a fair share of back-to-back beats
	function automatic int draw_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
	endfunction

	// mostly near the origin so trees grow into goal boxes, sometimes full range
	function automatic logic [CW-1:0] draw_coord();
		if ($urandom_range(0, 4) == 0)
			return CW'($urandom);
		return CW'($urandom_range(0, 32767) - 16384);
	endfunction

	// one input beat; valid stays up across back-to-back beats
	task automatic send_point(logic op, logic [CW-1:0] x, logic [CW-1:0] y,
			logic [CW-1:0] z);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{op: op, point_x: x, point_y: y, point_z: z};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// drain outstanding beats, then program all six registers
	task automatic set_regs(logic [CW-1:0] step, logic [CW-1:0] xlo, logic [CW-1:0] xhi,
			logic [CW-1:0] ylo, logic [CW-1:0] yhi, logic [CW-1:0] lim);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		reg_write(REG_STEP, step);
		reg_write(REG_GXLO, xlo);
		reg_write(REG_GXHI, xhi);
		reg_write(REG_GYLO, ylo);
		reg_write(REG_GYHI, yhi);
		reg_write(REG_EXTLIM, lim);
		cfg_valid <= 1'b0;
	endtask

	// a restart followed by mostly extends, the odd restart thrown in
	task automatic grow_tree(int n);
		send_point(OP_RESTART, draw_coord(), draw_coord(), draw_coord());
		for (int i = 0; i < n; i++)
			send_point(($urandom_range(0, 99) < 8) ? OP_RESTART : OP_EXTEND,
				draw_coord(), draw_coord(), draw_coord());
	endtask

	// receiver: random stall per beat, plus one long hold to back the block up
	initial begin
		int gap;
		out_stall <= 1'b1;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			gap = (results_seen == 60) ? 600 : draw_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int cx, cy, half;
		logic [CW-1:0] step;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extend with no tree, extreme points, ties, goal at origin
		send_point(OP_EXTEND, 24'd1, 24'd2, 24'd3);
		send_point(OP_RESTART, 24'h7FFFFF, 24'h800000, 24'h000000);
		send_point(OP_EXTEND, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
		send_point(OP_EXTEND, 24'h7FFFFF, 24'h800000, 24'h000000);
		send_point(OP_EXTEND, 24'h7FFFFF, 24'h800000, 24'h000000);
		send_point(OP_RESTART, 24'd0, 24'd0, 24'd0);
		send_point(OP_EXTEND, 24'd0, 24'd0, 24'd100);
		send_point(OP_EXTEND, 24'd50, 24'd50, 24'd50);

		// longest step, empty goal box, limit of two extensions
		set_regs(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'd2);
		send_point(OP_RESTART, -24'sd100, 24'd100, 24'd0);
		send_point(OP_EXTEND, 24'h800000, 24'h800000, 24'h800000);
		send_point(OP_EXTEND, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_point(OP_EXTEND, 24'd3, 24'd3, 24'd3);
		send_point(OP_EXTEND, 24'd4, 24'd4, 24'd4);

		// unit step, box over the whole plane, largest limit
		set_regs(24'd1, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'd1023);
		send_point(OP_RESTART, 24'd5, 24'd5, 24'd5);
		send_point(OP_EXTEND, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		send_point(OP_EXTEND, 24'd9, 24'd9, 24'd9);

		// limit of one extension
		set_regs(24'd256, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1);
		grow_tree(4);

		// random phases: varied steps, goal boxes and limits
		for (int p = 0; p < 8; p++) begin
			cx = $urandom_range(0, 16383) - 8192;
			cy = $urandom_range(0, 16383) - 8192;
			half = $urandom_range(0, 3000);
			case ($urandom_range(0, 3))
				0: step = CW'($urandom_range(1, 8388607));
				1: step = 1;
				default: step = CW'($urandom_range(16, 4096));
			endcase
			if (p == 0)
				step = 24'h7FFFFF;
			if ($urandom_range(0, 4) == 0)
				set_regs(step, CW'(cx + half), CW'(cx - half - 1), CW'(cy), CW'(cy),
					(p == 1) ? 24'd1023 : CW'($urandom_range(1, 1023)));
			else
				set_regs(step, CW'(cx - half), CW'(cx + half), CW'(cy - half),
					CW'(cy + half), (p == 2) ? 24'd1 : CW'($urandom_range(1, 80)));
			grow_tree(64);
		end
		in_valid <= 1'b0;

		// drain, then allow for the block's own latency
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
